FILE: rtl/fpl_pkg.sv
// shared constants, codes and control structs for the fault persistence logger
`timescale 1ns / 1ps
package fpl_pkg;

	localparam int NUM_IDS_DEF = 64;

	localparam int ACT_W   = 3;
	localparam int ID_W    = 6;
	localparam int TIME_W  = 64;
	localparam int SEV_W   = 4;
	localparam int DELAY_W = 32;

	typedef enum logic [ACT_W-1:0] {
		ACT_PERSIST_ACTIVE   = 3'd0,
		ACT_PERSIST_INACTIVE = 3'd1,
		ACT_DIRECT           = 3'd2,
		ACT_CLEAR_ALL        = 3'd3,
		ACT_READ             = 3'd4,
		ACT_SET_ENTRY        = 3'd5
	} action_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic commit;
		logic walk;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic clear_item;
		logic walk_last;
	} status_t;

endpackage

FILE: rtl/fpl_ctrl.sv
// controller state machine: item accept, evaluation and table clearing walk
`timescale 1ns / 1ps
module fpl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  fpl_pkg::status_t status,
	output fpl_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_EVAL  = 3'b010,
		ST_CLEAR = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		cmd.walk    = 1'b0;
		in_stall    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				// hold until the result register can take the new result
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = status.clear_item ? ST_CLEAR : ST_IDLE;
				end
			end
			ST_CLEAR: begin
				cmd.walk = 1'b1;
				if (status.walk_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// reset starts with a walk so the time tables come up zeroed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/fpl_datapath.sv
// datapath: time and entry tables, persistence check, latched state and result register
`timescale 1ns / 1ps
module fpl_datapath #(
	parameter int NUM_IDS = fpl_pkg::NUM_IDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fpl_pkg::cmd_t                cmd,
	output fpl_pkg::status_t             status,
	input  logic [fpl_pkg::ACT_W-1:0]    action,
	input  logic [fpl_pkg::ID_W-1:0]     fault_id,
	input  logic [fpl_pkg::TIME_W-1:0]   now_us,
	input  logic [fpl_pkg::SEV_W-1:0]    entry_severity,
	input  logic [fpl_pkg::DELAY_W-1:0]  entry_delay_us,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [fpl_pkg::SEV_W-1:0]    worst_severity,
	output logic [fpl_pkg::TIME_W-1:0]   active_time_us,
	output logic [fpl_pkg::TIME_W-1:0]   reset_time_us,
	output logic                         qualified
);

	localparam int IDX_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
	localparam int EXT_W = 16;

	logic [fpl_pkg::TIME_W-1:0]  active_mem  [NUM_IDS];
	logic [fpl_pkg::TIME_W-1:0]  healthy_mem [NUM_IDS];
	logic [fpl_pkg::SEV_W-1:0]   sev_mem     [NUM_IDS];
	logic [fpl_pkg::DELAY_W-1:0] delay_mem   [NUM_IDS];

	// captured item
	logic [fpl_pkg::ACT_W-1:0]   act_q;
	logic                        id_valid_q;
	logic [IDX_W-1:0]            idx_q;
	logic [fpl_pkg::TIME_W-1:0]  now_q;
	logic [fpl_pkg::SEV_W-1:0]   sev_in_q;
	logic [fpl_pkg::DELAY_W-1:0] delay_in_q;

	// table read data
	logic [fpl_pkg::TIME_W-1:0]  active_rd_q;
	logic [fpl_pkg::TIME_W-1:0]  healthy_rd_q;
	logic [fpl_pkg::SEV_W-1:0]   sev_rd_q;
	logic [fpl_pkg::DELAY_W-1:0] delay_rd_q;

	logic [fpl_pkg::SEV_W-1:0]   latched_q;
	logic [fpl_pkg::TIME_W-1:0]  last_clear_q;
	logic [IDX_W-1:0]            walk_q;
	logic                        out_valid_q;

	logic [EXT_W-1:0]            id_ext;
	logic [IDX_W-1:0]            idx_in;
	logic                        id_valid_in;
	logic [fpl_pkg::TIME_W-1:0]  due_time;
	logic                        due;
	logic                        is_clear;
	logic                        register_hit;
	logic                        active_wr;
	logic                        healthy_wr;
	logic                        entry_wr;
	logic [fpl_pkg::SEV_W-1:0]   latched_d;
	logic [fpl_pkg::TIME_W-1:0]  active_res;
	logic [fpl_pkg::TIME_W-1:0]  reset_res;

	assign id_ext      = {{(EXT_W-fpl_pkg::ID_W){1'b0}}, fault_id};
	assign idx_in      = id_ext[IDX_W-1:0];
	assign id_valid_in = 32'(fault_id) < 32'(NUM_IDS);

	always_comb begin
		is_clear     = act_q == fpl_pkg::ACT_CLEAR_ALL;
		// wraps at 64 bits
		due_time     = healthy_rd_q + fpl_pkg::TIME_W'(delay_rd_q);
		due          = due_time <= now_q;
		register_hit = id_valid_q &&
			((act_q == fpl_pkg::ACT_PERSIST_ACTIVE && due) || act_q == fpl_pkg::ACT_DIRECT);
		active_wr    = cmd.commit && register_hit;
		healthy_wr   = cmd.commit && id_valid_q && act_q == fpl_pkg::ACT_PERSIST_INACTIVE;
		entry_wr     = cmd.commit && id_valid_q && act_q == fpl_pkg::ACT_SET_ENTRY;

		latched_d = latched_q;
		if (is_clear) begin
			latched_d = '0;
		end else if (register_hit && sev_rd_q > latched_q) begin
			latched_d = sev_rd_q;
		end

		if (!id_valid_q || is_clear) begin
			active_res = '0;
		end else if (register_hit) begin
			active_res = now_q;
		end else begin
			active_res = active_rd_q;
		end

		reset_res = is_clear ? now_q : last_clear_q;
	end

	always_comb begin
		status.out_free   = !out_valid_q || !out_stall;
		status.clear_item = is_clear;
		status.walk_last  = walk_q == IDX_W'(NUM_IDS - 1);
	end

	// tables: one write and one registered read per cycle each
	always_ff @(posedge clk) begin
		if (cmd.walk) begin
			active_mem[walk_q] <= '0;
		end else if (active_wr) begin
			active_mem[idx_q] <= now_q;
		end
		if (cmd.capture) begin
			active_rd_q <= active_mem[idx_in];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk) begin
			healthy_mem[walk_q] <= last_clear_q;
		end else if (healthy_wr) begin
			healthy_mem[idx_q] <= now_q;
		end
		if (cmd.capture) begin
			healthy_rd_q <= healthy_mem[idx_in];
		end
	end

	always_ff @(posedge clk) begin
		if (entry_wr) begin
			sev_mem[idx_q]   <= sev_in_q;
			delay_mem[idx_q] <= delay_in_q;
		end
		if (cmd.capture) begin
			sev_rd_q   <= sev_mem[idx_in];
			delay_rd_q <= delay_mem[idx_in];
		end
	end

	// item capture and result payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q      <= action;
			id_valid_q <= id_valid_in;
			idx_q      <= idx_in;
			now_q      <= now_us;
			sev_in_q   <= entry_severity;
			delay_in_q <= entry_delay_us;
		end
		if (cmd.commit) begin
			worst_severity <= latched_d;
			active_time_us <= active_res;
			reset_time_us  <= reset_res;
			qualified      <= register_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q    <= '0;
			last_clear_q <= '0;
			walk_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.commit) begin
				latched_q    <= latched_d;
				last_clear_q <= reset_res;
			end
			if (cmd.walk) begin
				walk_q <= status.walk_last ? '0 : walk_q + 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/fault_persistence_logger_top.sv
// top level of the fault persistence logger
`timescale 1ns / 1ps
// Keeps per-identifier last-active and last-healthy times, a latched worst severity and the
// time of the last clear-all, and gives one result for every input transfer. An item is
// accepted and its table entries read; the evaluation step then checks persistence, updates
// the tables and loads the result register once it is free. A new item is accepted once the
// previous one has left the evaluation step, even while its result still waits at the output.
// After a clear-all result is loaded, a walk rewrites the time tables, one table entry a cycle
// through their write ports; after reset the same walk runs before the first item is taken.
// Identifiers at or above NUM_IDS leave the tables alone and read back a zero active time.
module fault_persistence_logger_top #(
	parameter int NUM_IDS = fpl_pkg::NUM_IDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [fpl_pkg::ACT_W-1:0]    action,
	input  logic [fpl_pkg::ID_W-1:0]     fault_id,
	input  logic [fpl_pkg::TIME_W-1:0]   now_us,
	input  logic [fpl_pkg::SEV_W-1:0]    entry_severity,
	input  logic [fpl_pkg::DELAY_W-1:0]  entry_delay_us,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [fpl_pkg::SEV_W-1:0]    worst_severity,
	output logic [fpl_pkg::TIME_W-1:0]   active_time_us,
	output logic [fpl_pkg::TIME_W-1:0]   reset_time_us,
	output logic                         qualified
);

	fpl_pkg::cmd_t    cmd;
	fpl_pkg::status_t status;

	fpl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	fpl_datapath #(
		.NUM_IDS (NUM_IDS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.action         (action),
		.fault_id       (fault_id),
		.now_us         (now_us),
		.entry_severity (entry_severity),
		.entry_delay_us (entry_delay_us),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.worst_severity (worst_severity),
		.active_time_us (active_time_us),
		.reset_time_us  (reset_time_us),
		.qualified      (qualified)
	);

endmodule

FILE: test/testbench.sv
// testbench for the fault persistence logger: directed and random fault events checked by a predictor
`timescale 1ns / 1ps
module testbench;

	localparam int CLK_PERIOD = 20;
	localparam int FAULT_SLOTS = fpl_pkg::NUM_IDS_DEF;
	localparam int RANDOM_PER_PHASE = 425;
	localparam int SETTLE_CYCLES = FAULT_SLOTS + 20;
	localparam int TIMEOUT_CYCLES = 500000;
	localparam logic [fpl_pkg::ACT_W-1:0] ACT_SPARE_LO = 3'd6;
	localparam logic [fpl_pkg::ACT_W-1:0] ACT_SPARE_HI = 3'd7;
	localparam logic [fpl_pkg::TIME_W-1:0] TIME_MAX = '1;

	typedef struct packed {
		logic [fpl_pkg::ACT_W-1:0]   act;
		logic [fpl_pkg::ID_W-1:0]    id;
		logic [fpl_pkg::TIME_W-1:0]  now;
		logic [fpl_pkg::SEV_W-1:0]   sev;
		logic [fpl_pkg::DELAY_W-1:0] delay;
	} fault_event_t;

	typedef struct packed {
		logic [fpl_pkg::SEV_W-1:0]  worst;
		logic [fpl_pkg::TIME_W-1:0] active;
		logic [fpl_pkg::TIME_W-1:0] cleared;
		logic                       hit;
	} log_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [fpl_pkg::ACT_W-1:0]    action = '0;
	logic [fpl_pkg::ID_W-1:0]     fault_id = '0;
	logic [fpl_pkg::TIME_W-1:0]   now_us = '0;
	logic [fpl_pkg::SEV_W-1:0]    entry_severity = '0;
	logic [fpl_pkg::DELAY_W-1:0]  entry_delay_us = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [fpl_pkg::SEV_W-1:0]    worst_severity;
	logic [fpl_pkg::TIME_W-1:0]   active_time_us;
	logic [fpl_pkg::TIME_W-1:0]   reset_time_us;
	logic                         qualified;

	fault_persistence_logger_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.fault_id       (fault_id),
		.now_us         (now_us),
		.entry_severity (entry_severity),
		.entry_delay_us (entry_delay_us),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.worst_severity (worst_severity),
		.active_time_us (active_time_us),
		.reset_time_us  (reset_time_us),
		.qualified      (qualified)
	);

	// predicted logger state
	logic [fpl_pkg::TIME_W-1:0]  last_active [FAULT_SLOTS];
	logic [fpl_pkg::TIME_W-1:0]  last_healthy [FAULT_SLOTS];
	logic [fpl_pkg::SEV_W-1:0]   id_severity [FAULT_SLOTS];
	logic [fpl_pkg::DELAY_W-1:0] id_delay [FAULT_SLOTS];
	logic [fpl_pkg::SEV_W-1:0]   latched_worst = '0;
	logic [fpl_pkg::TIME_W-1:0]  clear_stamp = '0;

	// stimulus state
	logic [fpl_pkg::TIME_W-1:0] gen_now = '0;
	logic [FAULT_SLOTS-1:0]     entry_written = '0;
	fault_event_t               send_queue[$];
	log_result_t                expected_results[$];
	logic                       in_fire = 1'b0;
	int                         in_idle_pct = 0;
	int                         out_stall_pct = 0;
	int                         mismatch_count = 0;
	int                         result_count = 0;

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("fault_persistence_logger_top regression: fail");
		$finish;
	end

	function automatic void raise_fault(logic [fpl_pkg::ID_W-1:0] id,
			logic [fpl_pkg::TIME_W-1:0] now);
		last_active[id] = now;
		if (id_severity[id] > latched_worst)
			latched_worst = id_severity[id];
	endfunction

	function automatic log_result_t apply_fault_event(fault_event_t ev);
		log_result_t res;
		logic id_ok;
		logic [fpl_pkg::TIME_W-1:0] due;
		res.hit = 1'b0;
		id_ok = int'(ev.id) < FAULT_SLOTS;
		case (ev.act)
			fpl_pkg::ACT_PERSIST_ACTIVE: begin
				if (id_ok) begin
					// sum wraps at 64 bits
					due = last_healthy[ev.id] + fpl_pkg::TIME_W'(id_delay[ev.id]);
					if (due <= ev.now) begin
						raise_fault(ev.id, ev.now);
						res.hit = 1'b1;
					end
				end
			end
			fpl_pkg::ACT_PERSIST_INACTIVE: begin
				if (id_ok)
					last_healthy[ev.id] = ev.now;
			end
			fpl_pkg::ACT_DIRECT: begin
				if (id_ok) begin
					raise_fault(ev.id, ev.now);
					res.hit = 1'b1;
				end
			end
			fpl_pkg::ACT_CLEAR_ALL: begin
				for (int i = 0; i < FAULT_SLOTS; i++) begin
					last_active[i] = '0;
					last_healthy[i] = ev.now;
				end
				latched_worst = '0;
				clear_stamp = ev.now;
			end
			fpl_pkg::ACT_SET_ENTRY: begin
				if (id_ok) begin
					id_severity[ev.id] = ev.sev;
					id_delay[ev.id] = ev.delay;
				end
			end
			default: ;
		endcase
		res.worst = latched_worst;
		res.active = id_ok ? last_active[ev.id] : '0;
		res.cleared = clear_stamp;
		return res;
	endfunction

	task automatic queue_event(logic [fpl_pkg::ACT_W-1:0] act, logic [fpl_pkg::ID_W-1:0] id,
			logic [fpl_pkg::TIME_W-1:0] now, logic [fpl_pkg::SEV_W-1:0] sev,
			logic [fpl_pkg::DELAY_W-1:0] delay);
		if (act == fpl_pkg::ACT_SET_ENTRY)
			entry_written[id] = 1'b1;
		send_queue.push_back({act, id, now, sev, delay});
	endtask

	function automatic logic [fpl_pkg::ID_W-1:0] pick_id();
		// half the traffic on a few identifiers so reports pile up on them
		if ($urandom_range(0, 1) == 1)
			return fpl_pkg::ID_W'($urandom_range(0, 7));
		return fpl_pkg::ID_W'($urandom_range(0, FAULT_SLOTS - 1));
	endfunction

	function automatic fault_event_t next_random_event();
		fault_event_t ev;
		int pick;
		int span;
		pick = $urandom_range(0, 99);
		span = $urandom_range(0, 99);
		if (span < 4)
			gen_now = {$urandom, $urandom};
		else if (span < 7)
			gen_now = TIME_MAX - $urandom_range(0, 3000);
		else
			gen_now = gen_now + $urandom_range(0, 250);
		ev.now = gen_now;
		ev.id = pick_id();
		ev.sev = fpl_pkg::SEV_W'($urandom);
		ev.delay = fpl_pkg::DELAY_W'($urandom);
		if (pick < 35)
			ev.act = fpl_pkg::ACT_PERSIST_ACTIVE;
		else if (pick < 55)
			ev.act = fpl_pkg::ACT_PERSIST_INACTIVE;
		else if (pick < 65)
			ev.act = fpl_pkg::ACT_DIRECT;
		else if (pick < 80)
			ev.act = fpl_pkg::ACT_READ;
		else if (pick < 95)
			ev.act = fpl_pkg::ACT_SET_ENTRY;
		else if (pick < 98)
			ev.act = fpl_pkg::ACT_CLEAR_ALL;
		else
			ev.act = pick[0] ? ACT_SPARE_LO : ACT_SPARE_HI;
		// persist-active and direct events only on identifiers that have an entry
		if ((ev.act == fpl_pkg::ACT_PERSIST_ACTIVE || ev.act == fpl_pkg::ACT_DIRECT) &&
				!entry_written[ev.id])
			ev.act = fpl_pkg::ACT_SET_ENTRY;
		if (ev.act == fpl_pkg::ACT_SET_ENTRY) begin
			case ($urandom_range(0, 4))
				0, 1, 2: ev.delay = fpl_pkg::DELAY_W'($urandom_range(0, 400));
				3: ev.delay = fpl_pkg::DELAY_W'($urandom_range(0, 5000));
				default: ;
			endcase
			entry_written[ev.id] = 1'b1;
		end
		return ev;
	endfunction

	task automatic flag_mismatch(string what);
		$display("mismatch at %0t ns, result %0d: %s", $time, result_count, what);
		mismatch_count++;
	endtask

	task automatic drain_all();
		while (send_queue.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk) begin
		fault_event_t ev;
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_stall <= 1'b0;
		end else begin
			out_stall <= $urandom_range(1, 100) <= out_stall_pct;
			if (!in_valid || in_fire) begin
				if (send_queue.size() != 0 && $urandom_range(1, 100) > in_idle_pct) begin
					ev = send_queue.pop_front();
					in_valid <= 1'b1;
					action <= ev.act;
					fault_id <= ev.id;
					now_us <= ev.now;
					entry_severity <= ev.sev;
					entry_delay_us <= ev.delay;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		log_result_t want;
		fault_event_t seen;
		in_fire <= arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				seen = {action, fault_id, now_us, entry_severity, entry_delay_us};
				expected_results.push_back(apply_fault_event(seen));
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					flag_mismatch("result transfer with nothing expected");
				end else begin
					want = expected_results.pop_front();
					if (worst_severity !== want.worst)
						flag_mismatch($sformatf("worst_severity %0h, expected %0h",
							worst_severity, want.worst));
					if (active_time_us !== want.active)
						flag_mismatch($sformatf("active_time_us %0h, expected %0h",
							active_time_us, want.active));
					if (reset_time_us !== want.cleared)
						flag_mismatch($sformatf("reset_time_us %0h, expected %0h",
							reset_time_us, want.cleared));
					if (qualified !== want.hit)
						flag_mismatch($sformatf("qualified %0b, expected %0b",
							qualified, want.hit));
				end
				result_count++;
			end
		end
	end

	initial begin
		for (int i = 0; i < FAULT_SLOTS; i++) begin
			last_active[i] = '0;
			last_healthy[i] = '0;
			id_severity[i] = '0;
			id_delay[i] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		queue_event(fpl_pkg::ACT_READ, 0, 0, 0, 0);
		queue_event(fpl_pkg::ACT_SET_ENTRY, 0, 1, 4'hF, 32'hFFFF_FFFF);
		queue_event(fpl_pkg::ACT_SET_ENTRY, 63, 2, 0, 0);
		queue_event(fpl_pkg::ACT_SET_ENTRY, 1, 3, 7, 100);
		queue_event(fpl_pkg::ACT_PERSIST_ACTIVE, 0, 5, 0, 0);
		// zero delay is due at once, even at time zero
		queue_event(fpl_pkg::ACT_PERSIST_ACTIVE, 63, 0, 0, 0);
		queue_event(fpl_pkg::ACT_DIRECT, 1, 50, 0, 0);
		queue_event(fpl_pkg::ACT_PERSIST_INACTIVE, 1, 1000, 0, 0);
		queue_event(fpl_pkg::ACT_PERSIST_ACTIVE, 1, 1099, 0, 0);
		queue_event(fpl_pkg::ACT_PERSIST_ACTIVE, 1, 1100, 0, 0);
		queue_event(fpl_pkg::ACT_DIRECT, 0, TIME_MAX, 0, 0);
		queue_event(fpl_pkg::ACT_READ, 0, 7, 0, 0);
		queue_event(ACT_SPARE_LO, 5, 64'h0123_4567_89AB_CDEF, 4'hA, 32'h5555_5555);
		queue_event(ACT_SPARE_HI, 63, TIME_MAX, 4'h5, 32'hAAAA_AAAA);
		queue_event(fpl_pkg::ACT_CLEAR_ALL, 0, TIME_MAX - 9, 0, 0);
		queue_event(fpl_pkg::ACT_READ, 63, 0, 0, 0);
		// healthy time near the top plus the largest delay wraps past zero
		queue_event(fpl_pkg::ACT_PERSIST_ACTIVE, 0, TIME_MAX - 4, 0, 0);
		queue_event(fpl_pkg::ACT_SET_ENTRY, 42, 0, 8, 32'h8000_0000);
		queue_event(fpl_pkg::ACT_PERSIST_INACTIVE, 42, 64'h8000_0000_0000_0000, 0, 0);
		queue_event(fpl_pkg::ACT_PERSIST_ACTIVE, 42, 64'h8000_0000_7FFF_FFFF, 0, 0);
		queue_event(fpl_pkg::ACT_DIRECT, 42, 64'h5555_5555_5555_5555, 0, 0);
		queue_event(fpl_pkg::ACT_CLEAR_ALL, 63, 0, 0, 0);
		queue_event(fpl_pkg::ACT_READ, 42, 0, 0, 0);

		// each phase is queued whole, then the sender holds until every result is back
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin in_idle_pct = 0; out_stall_pct = 0; end
				1: begin in_idle_pct = 77; out_stall_pct = 0; end
				2: begin in_idle_pct = 0; out_stall_pct = 77; end
				default: begin in_idle_pct = 28; out_stall_pct = 28; end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				send_queue.push_back(next_random_event());
			drain_all();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("fault_persistence_logger_top regression: pass");
		else
			$display("fault_persistence_logger_top regression: fail");
		$finish;
	end

endmodule

FILE: sim.f
rtl/fpl_pkg.sv
rtl/fpl_ctrl.sv
rtl/fpl_datapath.sv
rtl/fault_persistence_logger_top.sv
test/testbench.sv
